// ----- sv/mcwf_pkg.sv -----
// Shared types and constants for the minimum covering window finder.
package mcwf_pkg;

    localparam int KIND_W = 2;
    localparam int SYM_W  = 7;
    localparam int QDEPTH = 2;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_PATTERN = 2'd0;
    localparam kind_t KIND_TEXT    = 2'd1;
    localparam kind_t KIND_CLEAR   = 2'd2;

    typedef logic [1:0] op_t;

    localparam op_t OP_NOP     = 2'd0;
    localparam op_t OP_PATTERN = 2'd1;
    localparam op_t OP_TEXT    = 2'd2;
    localparam op_t OP_CLEAR   = 2'd3;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        logic  full;
        item_t item;
    } q_head_t;

endpackage

// ----- sv/mcwf_front.sv -----
// Front end: transaction accept and classification into back-end operations.
module mcwf_front #(
    parameter int ALPHABET = 128
) (
    input  logic                       start,
    input  mcwf_pkg::kind_t            kind,
    input  logic [mcwf_pkg::SYM_W-1:0] symbol,
    input  logic                       q_full,
    output logic                       busy,
    output mcwf_pkg::q_wr_t            q_wr
);

    logic in_alpha;
    mcwf_pkg::op_t op;

    // symbols beyond the alphabet never touch state
    assign in_alpha = ({2'b00, symbol} < 9'(ALPHABET));

    always_comb
    begin
        case (kind)
            mcwf_pkg::KIND_PATTERN: op = in_alpha ? mcwf_pkg::OP_PATTERN : mcwf_pkg::OP_NOP;
            mcwf_pkg::KIND_TEXT:    op = in_alpha ? mcwf_pkg::OP_TEXT : mcwf_pkg::OP_NOP;
            mcwf_pkg::KIND_CLEAR:   op = mcwf_pkg::OP_CLEAR;
            default:                op = mcwf_pkg::OP_NOP;
        endcase
    end

    assign busy             = q_full;
    assign q_wr.push        = start & ~q_full;
    assign q_wr.item.op     = op;
    assign q_wr.item.symbol = symbol;

endmodule

// ----- sv/mcwf_queue.sv -----
// Short FIFO of classified operations between front and back end.
module mcwf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  mcwf_pkg::q_wr_t   q_wr,
    input  logic              pop,
    output mcwf_pkg::q_head_t head
);

    localparam int QPW = (mcwf_pkg::QDEPTH > 1) ? $clog2(mcwf_pkg::QDEPTH) : 1;
    localparam int QCW = $clog2(mcwf_pkg::QDEPTH + 1);

    mcwf_pkg::item_t mem_reg [mcwf_pkg::QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    logic            do_pop;

    assign do_pop = pop & (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(mcwf_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(mcwf_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!q_wr.push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.item;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.full  = (cnt_reg == QCW'(mcwf_pkg::QDEPTH));
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

// ----- sv/mcwf_back.sv -----
// Back end: count tables, text buffer, window sequencer and best-window result.
module mcwf_back #(
    parameter int TEXT_DEPTH  = 4096,
    parameter int ALPHABET    = 128,
    parameter int PATTERN_MAX = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcwf_pkg::q_head_t                   head,
    output logic                                pop,
    output logic                                done,
    output logic                                found,
    output logic [$clog2(TEXT_DEPTH)-1:0]       best_start,
    output logic [$clog2(TEXT_DEPTH+1)-1:0]     best_length,
    output logic                                overflow
);

    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int PW  = $clog2(TEXT_DEPTH + 1);
    localparam int AW  = $clog2(ALPHABET);
    localparam int NW  = $clog2(PATTERN_MAX + 1);
    localparam int HW  = PW;
    localparam int CW  = (NW > HW) ? NW : HW;
    localparam int DW  = $clog2(ALPHABET + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PAT     = 3'd1;
    localparam logic [2:0] S_TXT     = 3'd2;
    localparam logic [2:0] S_ADV_CHK = 3'd3;
    localparam logic [2:0] S_ADV_TXT = 3'd4;
    localparam logic [2:0] S_ADV_CNT = 3'd5;
    localparam logic [2:0] S_EVAL    = 3'd6;

    // count table entry: {need, have}
    logic [NW+HW-1:0]          cnt_mem [ALPHABET];
    logic [mcwf_pkg::SYM_W-1:0] txt_mem [TEXT_DEPTH];

    logic [ALPHABET-1:0]       cnt_vld_reg;
    logic [NW+HW-1:0]          cnt_rd_reg;
    logic                      cnt_rd_vld_reg;
    logic [mcwf_pkg::SYM_W-1:0] txt_rd_reg;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [TAW-1:0] ws_reg, ws_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [TAW-1:0] bstart_reg, bstart_next;
    logic [PW-1:0]  blen_reg, blen_next;
    logic [DW-1:0]  deficit_reg, deficit_next;
    logic           done_reg, done_next;
    logic           ovf_reg, ovf_next;

    logic           cnt_re, cnt_we, vld_clr;
    logic [AW-1:0]  cnt_raddr, cnt_waddr;
    logic [NW+HW-1:0] cnt_wdata;
    logic           txt_re, txt_we;
    logic [TAW-1:0] txt_raddr, txt_waddr;
    logic [mcwf_pkg::SYM_W-1:0] txt_wdata;

    logic [NW-1:0]  need_q;
    logic [HW-1:0]  have_q;
    logic [CW-1:0]  need_x, have_x;
    logic [7:0]     head_sym_ext, txt_sym_ext;
    logic [PW-1:0]  ws_x, win_len;

    assign need_q = cnt_rd_vld_reg ? cnt_rd_reg[NW+HW-1:HW] : '0;
    assign have_q = cnt_rd_vld_reg ? cnt_rd_reg[HW-1:0] : '0;
    assign need_x = CW'(need_q);
    assign have_x = CW'(have_q);
    assign head_sym_ext = {1'b0, head.item.symbol};
    assign txt_sym_ext  = {1'b0, txt_rd_reg};
    assign ws_x    = PW'(ws_reg);
    assign win_len = pos_reg - ws_x;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ws_next      = ws_reg;
        pos_next     = pos_reg;
        bstart_next  = bstart_reg;
        blen_next    = blen_reg;
        deficit_next = deficit_reg;
        done_next    = 1'b0;
        ovf_next     = ovf_reg;
        pop          = 1'b0;
        vld_clr      = 1'b0;
        cnt_re       = 1'b0;
        cnt_raddr    = idx_reg;
        cnt_we       = 1'b0;
        cnt_waddr    = idx_reg;
        cnt_wdata    = {need_q, have_q};
        txt_re       = 1'b0;
        txt_raddr    = ws_reg;
        txt_we       = 1'b0;
        txt_waddr    = pos_reg[TAW-1:0];
        txt_wdata    = head.item.symbol;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    ovf_next  = 1'b0;
                    cnt_raddr = head_sym_ext[AW-1:0];
                    idx_next  = head_sym_ext[AW-1:0];
                    case (head.item.op)
                        mcwf_pkg::OP_PATTERN:
                        begin
                            cnt_re     = 1'b1;
                            state_next = S_PAT;
                        end
                        mcwf_pkg::OP_TEXT:
                        begin
                            if (pos_reg >= PW'(TEXT_DEPTH))
                            begin
                                ovf_next  = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                txt_we     = 1'b1;
                                cnt_re     = 1'b1;
                                state_next = S_TXT;
                            end
                        end
                        mcwf_pkg::OP_CLEAR:
                        begin
                            vld_clr      = 1'b1;
                            ws_next      = '0;
                            pos_next     = '0;
                            bstart_next  = '0;
                            blen_next    = '0;
                            deficit_next = '0;
                            done_next    = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_PAT:
            begin
                if (need_q < NW'(PATTERN_MAX))
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = {need_q + 1'b1, have_q};
                    // symbol was covered and now falls one short
                    if (have_x == need_x)
                    begin
                        deficit_next = deficit_reg + 1'b1;
                    end
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_TXT:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = {need_q, have_q + 1'b1};
                if (CW'(have_x + CW'(1)) == need_x)
                begin
                    deficit_next = deficit_reg - 1'b1;
                end
                pos_next   = pos_reg + 1'b1;
                state_next = S_ADV_CHK;
            end
            S_ADV_CHK:
            begin
                // window may only advance up to the newest character
                if (PW'(ws_x + PW'(1)) < pos_reg)
                begin
                    txt_re     = 1'b1;
                    state_next = S_ADV_TXT;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_ADV_TXT:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = txt_sym_ext[AW-1:0];
                idx_next   = txt_sym_ext[AW-1:0];
                state_next = S_ADV_CNT;
            end
            S_ADV_CNT:
            begin
                if (need_q == '0)
                begin
                    ws_next    = ws_reg + 1'b1;
                    state_next = S_ADV_CHK;
                end
                else if (have_x > need_x)
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = {need_q, have_q - 1'b1};
                    ws_next    = ws_reg + 1'b1;
                    state_next = S_ADV_CHK;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (deficit_reg == '0)
                begin
                    // strictly shorter only, so ties keep the earlier window
                    if ((blen_reg == '0) || (win_len < blen_reg))
                    begin
                        bstart_next = ws_reg;
                        blen_next   = win_len;
                    end
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            ws_reg      <= '0;
            pos_reg     <= '0;
            bstart_reg  <= '0;
            blen_reg    <= '0;
            deficit_reg <= '0;
            done_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            cnt_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ws_reg      <= ws_next;
            pos_reg     <= pos_next;
            bstart_reg  <= bstart_next;
            blen_reg    <= blen_next;
            deficit_reg <= deficit_next;
            done_reg    <= done_next;
            ovf_reg     <= ovf_next;
            if (vld_clr)
            begin
                cnt_vld_reg <= '0;
            end
            else if (cnt_we)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg     <= cnt_mem[cnt_raddr];
            cnt_rd_vld_reg <= cnt_vld_reg[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[txt_waddr] <= txt_wdata;
        end
        if (txt_re)
        begin
            txt_rd_reg <= txt_mem[txt_raddr];
        end
    end

    assign done        = done_reg;
    assign found       = (blen_reg != '0);
    assign best_start  = bstart_reg;
    assign best_length = blen_reg;
    assign overflow    = ovf_reg;

endmodule

// ----- sv/min_covering_window_finder.sv -----
// Top level of the minimum covering window finder.
// Usage: issue transactions with start while busy is low. kind 0 adds a
// pattern character (its need count saturates at PATTERN_MAX), kind 1 feeds a
// text character, kind 2 clears all counts, text and results, kind 3 does
// nothing. Every transaction returns exactly one result, marked by done for a
// single cycle; the receiver cannot stall it. found/best_start/best_length give
// the shortest covering window so far (ties keep the earlier one); overflow is
// high on a text result whose character was dropped because TEXT_DEPTH
// characters are already stored. A two-entry queue sits between the
// front end and the sequencer, so up to two transactions are taken while one
// is being worked on. A stored text character is counted, then the window
// start moves one character at a time (check, text read, count read) until it
// catches up with the newest character or stops on a needed one, and then the
// window is checked against the best so far. A single sequencer does this walk
// through the text buffer and count table, each a one-port memory with a
// registered read. No clearing pass: count-table entries carry valid bits that
// reset and clear drop at once.
module min_covering_window_finder #(
    parameter int TEXT_DEPTH  = 4096,
    parameter int ALPHABET    = 128,
    parameter int PATTERN_MAX = 255
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mcwf_pkg::KIND_W-1:0]     kind,
    input  logic [mcwf_pkg::SYM_W-1:0]      symbol,
    output logic                            busy,
    output logic                            done,
    output logic                            found,
    output logic [$clog2(TEXT_DEPTH)-1:0]   best_start,
    output logic [$clog2(TEXT_DEPTH+1)-1:0] best_length,
    output logic                            overflow
);

    mcwf_pkg::q_wr_t   q_wr;
    mcwf_pkg::q_head_t q_head;
    logic              q_pop;

    // front end: classify each transaction, push into the queue
    mcwf_front #(
        .ALPHABET (ALPHABET)
    ) u_front (
        .start  (start),
        .kind   (kind),
        .symbol (symbol),
        .q_full (q_head.full),
        .busy   (busy),
        .q_wr   (q_wr)
    );

    mcwf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .head  (q_head)
    );

    // back end: counts, text buffer, window walk, best window
    mcwf_back #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .ALPHABET    (ALPHABET),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .pop         (q_pop),
        .done        (done),
        .found       (found),
        .best_start  (best_start),
        .best_length (best_length),
        .overflow    (overflow)
    );

endmodule

// ----- sv/mcwf_checker.sv -----
// Port-level checker for the minimum covering window finder, with its bind.
module mcwf_checker #(
    parameter int TEXT_DEPTH = 4096
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            done,
    input logic                            found,
    input logic [$clog2(TEXT_DEPTH)-1:0]   best_start,
    input logic [$clog2(TEXT_DEPTH+1)-1:0] best_length,
    input logic                            overflow
);

    // found mirrors a nonzero best length
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        found == (best_length != '0))
        else $error("found disagrees with best_length");

    // without a window the start stays at zero
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !found |-> (best_start == '0))
        else $error("best_start nonzero without a window");

    // best window only shrinks until a clear
    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        found && $past(found) |-> (best_length <= $past(best_length)))
        else $error("best_length grew");

    // a dropped text character leaves the best window alone
    a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> $stable(best_length) && $stable(best_start))
        else $error("best window changed on overflow");

endmodule

bind min_covering_window_finder mcwf_checker #(
    .TEXT_DEPTH (TEXT_DEPTH)
) u_mcwf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .found       (found),
    .best_start  (best_start),
    .best_length (best_length),
    .overflow    (overflow)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the minimum covering window finder.
module testbench;

    localparam int TEXT_DEPTH  = 4096;
    localparam int ALPHABET    = 128;
    localparam int PATTERN_MAX = 255;
    localparam int SYM_W       = mcwf_pkg::SYM_W;
    localparam int START_W     = $clog2(TEXT_DEPTH);
    localparam int LEN_W       = $clog2(TEXT_DEPTH + 1);

    // kind 3 has no name in the package; the block treats it as a no-op.
    localparam mcwf_pkg::kind_t KIND_NOP = 2'd3;

    // Watchdog limit for about 800 transactions plus sender gaps.
    localparam int CYCLE_LIMIT    = 100000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 50;    // per idle phase
    localparam int SAT_TEXT_ITEMS = 280;
    localparam int PRINT_LIMIT    = 100;   // keep a broken run's log readable

    localparam logic [SYM_W-1:0] SYM_A = 7'h61;
    localparam logic [SYM_W-1:0] SYM_B = 7'h62;
    localparam logic [SYM_W-1:0] SYM_C = 7'h63;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start_pos;
        logic [LEN_W-1:0]   length;
        logic               ovf;
    } window_t;

    // Tracks pattern/text counts, predicts the best window for each accepted
    // transaction, and checks results against those predictions in order.
    class window_scoreboard;
        bit [7:0]         need_cnt [ALPHABET];
        bit [LEN_W-1:0]   have_cnt [ALPHABET];
        bit [SYM_W-1:0]   text_mem [TEXT_DEPTH];
        bit [START_W-1:0] win_start;
        bit [LEN_W-1:0]   text_len;
        bit [START_W-1:0] best_start;
        bit [LEN_W-1:0]   best_len;
        window_t          expected_windows [$];
        int               error_count;

        // Text memory is left alone: entries at or above text_len are never read.
        function void clear_state();
            foreach (need_cnt[i])
            begin
                need_cnt[i] = '0;
                have_cnt[i] = '0;
            end
            win_start  = '0;
            text_len   = '0;
            best_start = '0;
            best_len   = '0;
        endfunction

        function int pending();
            return expected_windows.size();
        endfunction

        function void note_item(mcwf_pkg::kind_t k, bit [SYM_W-1:0] sym);
            window_t w;
            int      pos;
            int      ch;
            int      span;
            bit      covered;
            w.ovf = 1'b0;
            case (k)
                mcwf_pkg::KIND_PATTERN:
                begin
                    // need count saturates
                    if (need_cnt[sym] < PATTERN_MAX)
                        need_cnt[sym]++;
                end
                mcwf_pkg::KIND_TEXT:
                begin
                    if (text_len >= TEXT_DEPTH)
                        w.ovf = 1'b1;   // buffer full, character dropped
                    else
                    begin
                        pos = text_len;
                        text_mem[pos] = sym;
                        have_cnt[sym]++;
                        text_len++;
                        // Slide start past unneeded and surplus characters.
                        while (win_start < pos)
                        begin
                            ch = text_mem[win_start];
                            if (need_cnt[ch] == 0)
                                win_start++;
                            else if (have_cnt[ch] > need_cnt[ch])
                            begin
                                have_cnt[ch]--;
                                win_start++;
                            end
                            else
                                break;
                        end
                        covered = 1'b1;
                        foreach (need_cnt[c])
                            if (have_cnt[c] < need_cnt[c])
                                covered = 1'b0;
                        span = pos - win_start + 1;
                        // strictly shorter only: ties keep the earlier window
                        if (covered && (best_len == 0 || span < best_len))
                        begin
                            best_start = win_start;
                            best_len   = LEN_W'(span);
                        end
                    end
                end
                mcwf_pkg::KIND_CLEAR:
                    clear_state();
                default:
                    ;
            endcase
            w.found     = (best_len != 0);
            w.start_pos = best_start;
            w.length    = best_len;
            expected_windows = {expected_windows, w};
        endfunction

        function void check_result(window_t got);
            window_t want;
            if (expected_windows.size() == 0)
            begin
                if (error_count < PRINT_LIMIT)
                    $display("%0t: unexpected result found=%0d start=%0d length=%0d overflow=%0d",
                             $time, got.found, got.start_pos, got.length, got.ovf);
                error_count++;
                return;
            end
            want = expected_windows.pop_front();
            if (got !== want)
            begin
                if (error_count < PRINT_LIMIT)
                    $display({"%0t: mismatch expected found=%0d start=%0d length=%0d ",
                              "overflow=%0d, actual found=%0d start=%0d length=%0d overflow=%0d"},
                             $time, want.found, want.start_pos, want.length, want.ovf,
                             got.found, got.start_pos, got.length, got.ovf);
                error_count++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    mcwf_pkg::kind_t    kind;
    logic [SYM_W-1:0]   symbol;
    logic               busy;
    logic               done;
    logic               found;
    logic [START_W-1:0] best_start;
    logic [LEN_W-1:0]   best_length;
    logic               overflow;

    window_scoreboard window_sb;
    int               idle_pct;      // chance in 100 of a gap before each transaction
    int               items_sent;    // transactions that can change state
    int               cycle_count;

    min_covering_window_finder #(
        .TEXT_DEPTH  (TEXT_DEPTH),
        .ALPHABET    (ALPHABET),
        .PATTERN_MAX (PATTERN_MAX)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .symbol      (symbol),
        .busy        (busy),
        .done        (done),
        .found       (found),
        .best_start  (best_start),
        .best_length (best_length),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitor. Results are checked before the new transaction is noted; a result
    // on the same edge always belongs to an older transaction (queue and done are registered).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                window_sb.check_result(window_t'{found, best_start, best_length, overflow});
            if (start && !busy)
                window_sb.note_item(kind, symbol);
        end
    end

    // Drive one transaction. Inputs move on the falling edge; the task returns
    // at the rising edge where busy was low, i.e. where the block took it.
    // start is held high across back-to-back transactions.
    task automatic send_item(input mcwf_pkg::kind_t k, input logic [SYM_W-1:0] sym);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        kind   <= k;
        symbol <= sym;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k != KIND_NOP)
            items_sent++;
    endtask

    // Mostly well-formed runs: usually a clear, a short pattern over a few letters, then
    // text drawn mostly from those letters, with a late pattern character or a
    // no-op mixed in now and then. The rest is noise over all kinds and symbols.
    task automatic run_random(input int n_items);
        logic [SYM_W-1:0] letters [5];
        int               n_letters;
        int               stop_at;
        int               r;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(99) < 80)
                    send_item(mcwf_pkg::KIND_CLEAR, SYM_W'($urandom_range(127)));
                n_letters = $urandom_range(5, 2);
                foreach (letters[i])
                    letters[i] = SYM_W'($urandom_range(127));
                repeat ($urandom_range(6, 1))
                    send_item(mcwf_pkg::KIND_PATTERN, letters[$urandom_range(n_letters - 1)]);
                repeat ($urandom_range(40, 4))
                begin
                    r = $urandom_range(99);
                    if (r < 80)
                        send_item(mcwf_pkg::KIND_TEXT, letters[$urandom_range(n_letters - 1)]);
                    else if (r < 92)
                        send_item(mcwf_pkg::KIND_TEXT, SYM_W'($urandom_range(127)));
                    else if (r < 97)
                        send_item(mcwf_pkg::KIND_PATTERN,
                                  letters[$urandom_range(n_letters - 1)]);
                    else
                        send_item(KIND_NOP, SYM_W'($urandom_range(127)));
                end
            end
            else
                send_item(mcwf_pkg::kind_t'($urandom_range(3)), SYM_W'($urandom_range(127)));
        end
    endtask

    initial
    begin
        int i;
        start       = 1'b0;
        kind        = mcwf_pkg::KIND_PATTERN;
        symbol      = '0;
        rst_n       = 1'b0;
        cycle_count = 0;
        items_sent  = 0;
        idle_pct    = 16;
        window_sb   = new;
        window_sb.clear_state();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: no-op from reset, empty pattern (first text char covers),
        // symbol extremes, duplicate pattern chars, pattern added after text,
        // clear back to nothing found.
        send_item(KIND_NOP,               7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd127);
        send_item(mcwf_pkg::KIND_TEXT,    7'd0);
        send_item(mcwf_pkg::KIND_CLEAR,   7'd127);
        send_item(mcwf_pkg::KIND_PATTERN, 7'd0);
        send_item(mcwf_pkg::KIND_PATTERN, 7'd127);
        send_item(mcwf_pkg::KIND_PATTERN, 7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd127);
        send_item(mcwf_pkg::KIND_TEXT,    7'd5);
        send_item(mcwf_pkg::KIND_TEXT,    7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd64);
        send_item(mcwf_pkg::KIND_TEXT,    7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd127);
        send_item(mcwf_pkg::KIND_TEXT,    7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd0);
        send_item(mcwf_pkg::KIND_TEXT,    7'd127);
        send_item(mcwf_pkg::KIND_PATTERN, 7'd64);
        send_item(mcwf_pkg::KIND_TEXT,    7'd5);
        send_item(mcwf_pkg::KIND_TEXT,    7'd64);
        send_item(KIND_NOP,               7'd127);
        send_item(mcwf_pkg::KIND_CLEAR,   7'd0);
        send_item(KIND_NOP,               7'd85);

        run_random(RANDOM_ITEMS);

        idle_pct = 63;
        run_random(RANDOM_ITEMS);

        // No gaps from here on. Push one need count past its bound, then feed
        // text that is mostly 'a' so the saturated count can still be met.
        idle_pct = 0;
        send_item(mcwf_pkg::KIND_CLEAR, 7'd0);
        repeat (PATTERN_MAX + 5)
            send_item(mcwf_pkg::KIND_PATTERN, SYM_A);
        send_item(mcwf_pkg::KIND_PATTERN, SYM_B);
        for (i = 0; i < SAT_TEXT_ITEMS; i++)
        begin
            if ($urandom_range(99) < 95)
                send_item(mcwf_pkg::KIND_TEXT, SYM_A);
            else
                send_item(mcwf_pkg::KIND_TEXT, $urandom_range(1) ? SYM_B : SYM_C);
        end
        send_item(mcwf_pkg::KIND_PATTERN, SYM_C);
        send_item(mcwf_pkg::KIND_TEXT, SYM_C);
        send_item(KIND_NOP, 7'd127);
        send_item(mcwf_pkg::KIND_CLEAR, 7'd0);

        run_random(RANDOM_ITEMS);

        @(negedge clk);
        start <= 1'b0;

        // Drain, then keep watching for any stray result.
        while (window_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (window_sb.error_count == 0 && window_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/mcwf_pkg.sv
sv/mcwf_front.sv
sv/mcwf_queue.sv
sv/mcwf_back.sv
sv/min_covering_window_finder.sv
sv/mcwf_checker.sv
test/testbench.sv
